>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the fingerprint unit's RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in a cycle implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/smff_pkg.sv
// Types and constants for the fingerprint fold unit.
package smff_pkg;

	localparam logic [63:0] START_CONST = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
	localparam int unsigned MIX_SH_A    = 30;
	localparam int unsigned MIX_SH_B    = 27;
	localparam int unsigned MIX_SH_C    = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_SHIFT_B,
		ST_MUL_B,
		ST_SHIFT_C,
		ST_COMBINE
	} state_t;

	// Partial product of a 64x64 multiply, low 64 bits only.
	typedef enum logic [1:0] {
		STEP_LO_LO,
		STEP_HI_LO,
		STEP_LO_HI
	} mul_step_t;

	typedef struct packed {
		logic      load;
		logic      mul;
		logic      sel_b;
		mul_step_t step;
		logic      shift_b;
		logic      shift_c;
		logic      combine;
		logic      emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/splitmix_fold_fingerprint_unit.sv
// Top level of the fingerprint fold unit: controller plus datapath.
//
// Usage: each request on the word channel (word, last) carries one 64-bit
// block of a value, in order; last marks the value's final block. Every word
// goes through a SplitMix64-style finaliser and is folded into a running hash
// with an order-sensitive add/shift/xor combine. A request with last set
// produces one fingerprint request; other words produce nothing.
// Sequence: one request is worked on at a time. The word is taken
// in idle, then each 64-bit multiply runs as three 32x32 partial products on a
// single shared multiplier, with one state for each of the two later xor-shifts and
// one for the combine. For a last word, fingerprint_valid rises at the edge
// at which word_stall drops.
// Output: the fingerprint sits in a register, so the next word is taken while
// a finished fingerprint still waits. If a second fingerprint is ready while
// the first is still stalled, the unit holds in its combine step until the
// register frees.
// Reset (arst_n low, asynchronous) returns the hash to its start constant,
// drops fingerprint_valid and puts the controller in idle.

module splitmix_fold_fingerprint_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [63:0] word,
	input  logic        last,
	output logic        fingerprint_valid,
	input  logic        fingerprint_stall,
	output logic [63:0] fingerprint
);

	smff_pkg::cmd_t cmd;
	smff_pkg::sts_t sts;

	// sequencing of one request
	smff_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// arithmetic, hash state and output register
	smff_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.word              (word),
		.last              (last),
		.fingerprint_valid (fingerprint_valid),
		.fingerprint_stall (fingerprint_stall),
		.fingerprint       (fingerprint)
	);

endmodule

>>> hw/rtl/smff_dp.sv
// Datapath: mixer operand, shared 32x32 multiplier, running hash, output register.
`include "assert_macros.svh"

module smff_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  smff_pkg::cmd_t    cmd,
	output smff_pkg::sts_t    sts,
	input  logic [63:0]       word,
	input  logic              last,
	output logic              fingerprint_valid,
	input  logic              fingerprint_stall,
	output logic [63:0]       fingerprint
);

	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] hash_q;
	logic [63:0] fp_q;
	logic        last_q;
	logic        out_valid_q;

	logic [63:0] mul_const;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [63:0] hash_new;

	always_comb begin
		mul_const = cmd.sel_b ? smff_pkg::MIX_MUL_B : smff_pkg::MIX_MUL_A;
		op_a = (cmd.step == smff_pkg::STEP_HI_LO) ? x_q[63:32] : x_q[31:0];
		op_b = (cmd.step == smff_pkg::STEP_LO_HI) ? mul_const[63:32] : mul_const[31:0];
		prod = 64'(op_a) * 64'(op_b);
		hash_new = hash_q ^ (x_q + smff_pkg::START_CONST + (hash_q << 6) + (hash_q >> 2));
	end

	// x_q holds the operand of each multiply, and finally the mixed word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= word ^ (word >> smff_pkg::MIX_SH_A);
			last_q <= last;
		end else if (cmd.shift_b) begin
			x_q <= acc_q ^ (acc_q >> smff_pkg::MIX_SH_B);
		end else if (cmd.shift_c) begin
			x_q <= acc_q ^ (acc_q >> smff_pkg::MIX_SH_C);
		end
		if (cmd.mul) begin
			if (cmd.step == smff_pkg::STEP_LO_LO) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'd0};
			end
		end
		if (cmd.emit) begin
			fp_q <= hash_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= smff_pkg::START_CONST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.combine) begin
				hash_q <= last_q ? smff_pkg::START_CONST : hash_new;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!fingerprint_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last          = last_q;
	assign sts.out_free      = !out_valid_q || !fingerprint_stall;
	assign fingerprint_valid = out_valid_q;
	assign fingerprint       = fp_q;

	`ASSERT_NEXT(a_hash_restart, cmd.combine && last_q, hash_q == smff_pkg::START_CONST, "hash not restarted after last word")
	`ASSERT_SAME(a_emit_on_last, cmd.emit, cmd.combine && last_q, "emit outside a last-word combine")
	`ASSERT_NEXT(a_emit_shows, cmd.emit, fingerprint_valid, "emitted fingerprint not presented")

endmodule

>>> hw/rtl/smff_ctrl.sv
// Controller: sequences load, two split multiplies, shifts and the combine.
`include "assert_macros.svh"

module smff_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           word_valid,
	output logic           word_stall,
	input  smff_pkg::sts_t sts,
	output smff_pkg::cmd_t cmd
);

	smff_pkg::state_t    state_q;
	smff_pkg::state_t    state_d;
	smff_pkg::mul_step_t step_q;
	smff_pkg::mul_step_t step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smff_pkg::ST_IDLE;
			step_q  <= smff_pkg::STEP_LO_LO;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = smff_pkg::STEP_LO_LO;
		cmd     = '0;
		cmd.step = step_q;
		case (step_q)
			smff_pkg::STEP_LO_LO: step_d = smff_pkg::STEP_HI_LO;
			smff_pkg::STEP_HI_LO: step_d = smff_pkg::STEP_LO_HI;
			default:              step_d = smff_pkg::STEP_LO_LO;
		endcase
		case (state_q)
			smff_pkg::ST_IDLE: begin
				step_d   = smff_pkg::STEP_LO_LO;
				cmd.load = word_valid;
				if (word_valid) begin
					state_d = smff_pkg::ST_MUL_A;
				end
			end
			smff_pkg::ST_MUL_A: begin
				cmd.mul = 1'b1;
				if (step_q == smff_pkg::STEP_LO_HI) begin
					state_d = smff_pkg::ST_SHIFT_B;
				end
			end
			smff_pkg::ST_SHIFT_B: begin
				step_d      = smff_pkg::STEP_LO_LO;
				cmd.shift_b = 1'b1;
				state_d     = smff_pkg::ST_MUL_B;
			end
			smff_pkg::ST_MUL_B: begin
				cmd.mul   = 1'b1;
				cmd.sel_b = 1'b1;
				if (step_q == smff_pkg::STEP_LO_HI) begin
					state_d = smff_pkg::ST_SHIFT_C;
				end
			end
			smff_pkg::ST_SHIFT_C: begin
				step_d      = smff_pkg::STEP_LO_LO;
				cmd.shift_c = 1'b1;
				state_d     = smff_pkg::ST_COMBINE;
			end
			smff_pkg::ST_COMBINE: begin
				step_d = smff_pkg::STEP_LO_LO;
				// a final word waits here until the output register can take it
				if (!sts.last || sts.out_free) begin
					cmd.combine = 1'b1;
					cmd.emit    = sts.last;
					state_d     = smff_pkg::ST_IDLE;
				end
			end
			default: begin
				step_d  = smff_pkg::STEP_LO_LO;
				state_d = smff_pkg::ST_IDLE;
			end
		endcase
	end

	assign word_stall = (state_q != smff_pkg::ST_IDLE);

	`ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free, "emit while output register is held")
	`ASSERT_NEXT(a_accept_starts, !word_stall && word_valid, state_q == smff_pkg::ST_MUL_A && step_q == smff_pkg::STEP_LO_LO, "accepted request did not start the mixer")
	`ASSERT_SAME(a_mul_step_range, cmd.mul, step_q == smff_pkg::STEP_LO_LO || step_q == smff_pkg::STEP_HI_LO || step_q == smff_pkg::STEP_LO_HI, "multiply step out of range")

endmodule

>>> sim/splitmix_fold_fingerprint_unit_tb.sv
// Self-checking testbench for the SplitMix64 fingerprint fold unit.
`timescale 1ns / 1ps

module splitmix_fold_fingerprint_unit_tb;

	// 4 ns clock period; reset length in clock cycles
	localparam int unsigned RESET_CYCLES  = 8;
	// random part stops once this many words have gone in
	localparam int unsigned RANDOM_WORDS  = 1200;
	// receiver hold-off for the back-pressure test, long enough to fill the unit
	localparam int unsigned HOLD_CYCLES   = 300;
	// cycles with no request moving on either channel before we give up;
	// covers the hold-off above plus the longest gaps and the fold
	localparam int unsigned STALL_LIMIT   = 2000;
	// settle time after the last fingerprint
	localparam int unsigned DRAIN_CYCLES  = 40;

	logic        clk;
	logic        arst_n;
	logic        word_valid;
	logic        word_stall;
	logic [63:0] word;
	logic        last;
	logic        fingerprint_valid;
	logic        fingerprint_stall;
	logic [63:0] fingerprint;

	// Predictor state: running hash and the fingerprints still owed by the unit.
	logic [63:0] hash_acc;
	logic [63:0] pending_fingerprints[$];

	int unsigned mismatch_count;
	int unsigned words_sent;

	// Idling controls shared between the tests and the two channel processes.
	bit tx_eager;       // sender offers back to back, no gaps
	bit rx_eager;       // receiver never stalls
	bit hold_request;   // receiver to do one long hold-off

	splitmix_fold_fingerprint_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.word_valid        (word_valid),
		.word_stall        (word_stall),
		.word              (word),
		.last              (last),
		.fingerprint_valid (fingerprint_valid),
		.fingerprint_stall (fingerprint_stall),
		.fingerprint       (fingerprint)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// SplitMix64 finaliser, all arithmetic mod 2^64.
	function automatic logic [63:0] splitmix_finalise(input logic [63:0] x);
		x = x ^ (x >> smff_pkg::MIX_SH_A);
		x = x * smff_pkg::MIX_MUL_A;
		x = x ^ (x >> smff_pkg::MIX_SH_B);
		x = x * smff_pkg::MIX_MUL_B;
		x = x ^ (x >> smff_pkg::MIX_SH_C);
		return x;
	endfunction

	// Fold one accepted word into the hash; a last word owes one fingerprint
	// and puts the hash back to its start value.
	task automatic fold_word(input logic [63:0] w, input logic l);
		logic [63:0] h;
		h = hash_acc ^ (splitmix_finalise(w) + smff_pkg::START_CONST + (hash_acc << 6)
			+ (hash_acc >> 2));
		if (l) begin
			pending_fingerprints.push_back(h);
			hash_acc = smff_pkg::START_CONST;
		end else begin
			hash_acc = h;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly no gap, some short, a few long.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Random word; a share of corner patterns so the edges of the
	// multiplies and shifts get exercised, the rest uniform.
	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return ~(64'd1 << $urandom_range(0, 63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Drop valid and scramble the idle payload; nothing is done when n is zero.
	task automatic idle_words(input int unsigned n);
		if (n != 0) begin
			word_valid <= 1'b0;
			word       <= {$urandom, $urandom};
			last       <= 1'($urandom_range(0, 1));
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one word request and hold it until the unit takes it.
	// Called at a rising edge; returns at the accepting edge (or after a gap).
	task automatic send_word(input logic [63:0] w, input logic l);
		word_valid <= 1'b1;
		word       <= w;
		last       <= l;
		do
			@(posedge clk);
		while (word_stall);
		fold_word(w, l);
		words_sent++;
		if (!tx_eager)
			idle_words(gap_len());
	endtask

	// A whole value of n words, last on the final one.
	task automatic send_value(input int unsigned n);
		int unsigned i;
		for (i = 1; i <= n; i++)
			send_word(pick_word(), i == n);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Receiver: random stalls, eager stretches, and one long hold-off on request.
	initial begin : receiver
		int unsigned hold_len;
		forever begin
			if (hold_request) begin
				fingerprint_stall <= 1'b1;
				hold_len = HOLD_CYCLES;
				hold_request = 1'b0;
			end else if (!rx_eager) begin
				hold_len = gap_len();
				fingerprint_stall <= (hold_len != 0);
				if (hold_len == 0)
					hold_len = 1;
			end else begin
				fingerprint_stall <= 1'b0;
				hold_len = 1;
			end
			repeat (hold_len) @(posedge clk);
		end
	end

	// Every accepted fingerprint request against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && fingerprint_valid && !fingerprint_stall) begin
			if (pending_fingerprints.size() == 0)
				report_mismatch("fingerprint with none owed", fingerprint, '0);
			else if (fingerprint !== pending_fingerprints[0]) begin
				report_mismatch("fingerprint", fingerprint, pending_fingerprints[0]);
				void'(pending_fingerprints.pop_front());
			end else begin
				void'(pending_fingerprints.pop_front());
			end
		end
	end

	// Watchdog: too long with no request moving on either side.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((word_valid && !word_stall) || (fingerprint_valid && !fingerprint_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TIMEOUT: nothing moved for %0d cycles, %0d fingerprints owed",
			quiet, pending_fingerprints.size());
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// One-word values at the field extremes; each is its own last word.
	task automatic test_single_word_extremes();
		send_word(64'h0000_0000_0000_0000, 1'b1);
		send_word(64'hffff_ffff_ffff_ffff, 1'b1);
		send_word(64'h0000_0000_0000_0001, 1'b1);
		send_word(64'h8000_0000_0000_0000, 1'b1);
		send_word(64'h5555_5555_5555_5555, 1'b1);
		send_word(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		send_word(smff_pkg::START_CONST, 1'b1);
		send_word(64'h0000_0000_ffff_ffff, 1'b1);
	endtask

	// Multi-word values: non-last words give nothing, word order matters,
	// and the hash restarts after each last word.
	task automatic test_multi_word_order();
		logic [63:0] a;
		logic [63:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		send_word(a, 1'b0);
		send_word(b, 1'b1);
		send_word(b, 1'b0);
		send_word(a, 1'b1);
		// all-zero words: mixer output zero, only the combine moves the hash
		send_word('0, 1'b0);
		send_word('0, 1'b0);
		send_word('0, 1'b1);
		send_word('1, 1'b0);
		send_word('1, 1'b1);
	endtask

	// No idling on either side: requests offered as fast as the unit takes them.
	task automatic test_back_to_back();
		tx_eager = 1'b1;
		rx_eager = 1'b1;
		send_value(1);
		send_value(2);
		send_value(1);
		send_value(2);
		tx_eager = 1'b0;
		rx_eager = 1'b0;
	endtask

	// Receiver holds off for a long stretch while words keep coming: the
	// output register fills, the unit parks in its combine step and has to
	// stall the word channel until fingerprints drain.
	task automatic test_output_hold_off();
		int unsigned i;
		tx_eager = 1'b1;
		hold_request = 1'b1;
		for (i = 0; i < 24; i++)
			send_word(pick_word(), $urandom_range(0, 3) != 0);
		tx_eager = 1'b0;
	endtask

	// Random values, mostly short, some medium, a few long; eager stretches
	// switched on and off on each side now and then.
	task automatic test_random_values();
		int unsigned r;
		int unsigned n;
		while (words_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 15) == 0)
				tx_eager = !tx_eager;
			if ($urandom_range(0, 15) == 0)
				rx_eager = !rx_eager;
			r = $urandom_range(0, 99);
			if (r < 70)
				n = $urandom_range(1, 4);
			else if (r < 95)
				n = $urandom_range(5, 12);
			else
				n = $urandom_range(20, 40);
			send_value(n);
			// back-pressure once more partway through
			if (words_sent >= RANDOM_WORDS / 2 && words_sent < RANDOM_WORDS / 2 + n)
				test_output_hold_off();
		end
		tx_eager = 1'b0;
		rx_eager = 1'b0;
	endtask

	initial begin : main
		word_valid     <= 1'b0;
		word           <= '0;
		last           <= 1'b0;
		arst_n         <= 1'b0;
		hash_acc       = smff_pkg::START_CONST;
		mismatch_count = 0;
		words_sent     = 0;
		tx_eager       = 1'b0;
		rx_eager       = 1'b0;
		hold_request   = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_word_extremes();
		test_multi_word_order();
		test_back_to_back();
		test_output_hold_off();
		words_sent = 0;
		test_random_values();

		// everything offered has been taken; wait for the owed fingerprints,
		// then a little longer to catch any stray request
		idle_words(1);
		while (pending_fingerprints.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_fingerprints.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> splitmix_fold_fingerprint_unit.f
+incdir+hw/rtl
hw/rtl/smff_pkg.sv
hw/rtl/smff_dp.sv
hw/rtl/smff_ctrl.sv
hw/rtl/splitmix_fold_fingerprint_unit.sv
sim/splitmix_fold_fingerprint_unit_tb.sv
